// ===== rtl/abl_pkg.sv =====
// Package for the angle bisector line coefficient unit.
// Widths, payload types and the carried-context struct; no dependencies.
package abl_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int RAD_W       = 2 * DIFF_W;
    localparam int ROOT_W      = DIFF_W;
    localparam int COEF_W      = COORD_WIDTH + 2;
    localparam int SUM_W       = COORD_WIDTH + 3;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int C_W         = 64;
    localparam int CALC_W      = (PROD_W + 1 > C_W) ? PROD_W + 1 : C_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]      t_coef;
    typedef logic signed [C_W-1:0]         t_cval;

    typedef struct packed {
        t_coord vx;
        t_coord vy;
        t_coord rx;
        t_coord ry;
        logic   nx;
        logic   ny;
    } t_carry;
endpackage

// ===== rtl/abl_if.sv =====
// Stream interfaces for the angle bisector line coefficient unit.
// Valid/ready channels carrying the item and result payloads; uses abl_pkg.
interface abl_in_if;
    import abl_pkg::*;
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord right_x;
    t_coord right_y;
    t_coord left_x;
    t_coord left_y;
    modport source (output valid, vertex_x, vertex_y, right_x, right_y, left_x, left_y,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, right_x, right_y, left_x, left_y,
                  output ready);
endinterface

interface abl_out_if;
    import abl_pkg::*;
    logic  valid;
    logic  ready;
    t_coef coef_a;
    t_coef coef_b;
    t_cval coef_c;
    logic  degenerate;
    modport source (output valid, coef_a, coef_b, coef_c, degenerate, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, degenerate, output ready);
endinterface

// ===== rtl/angle_bisector_line_coeffs_unit.sv =====
// Angle bisector line coefficient unit: pipelined square roots, dividers, multipliers.
// Depends on abl_pkg and the stream interfaces in abl_if.sv.
//
//   channel | dir | payload
//   i_in    | in  | vertex_x, vertex_y, right_x, right_y, left_x, left_y
//   o_out   | out | coef_a, coef_b, coef_c, degenerate
//
// Accepts one item per cycle while the output is not stalled.
// The square root and divider pipelines resolve one bit per stage.
// Reset clears the valid bits only; the payload flows without reset.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
module angle_bisector_line_coeffs_unit (
    input logic      i_clk,
    input logic      i_rst_n,
    abl_in_if.sink   i_in,
    abl_out_if.source o_out
);
    import abl_pkg::*;

    function automatic logic [DIFF_W-1:0] f_mag(input logic signed [DIFF_W-1:0] d);
        f_mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic en;

    // input stage
    logic                    r_s0v;
    t_carry                  r_s0c;
    logic [DIFF_W-1:0]       r_s0m [0:3];
    logic signed [DIFF_W-1:0] n_d  [0:3];

    // squares
    logic                    r_s1v;
    t_carry                  r_s1c;
    logic [RAD_W-1:0]        r_s1q [0:3];
    logic [DIFF_W-1:0]       r_s1m [0:1];

    // square root pipeline, entry 0 holds the radicands
    logic                    r_sv    [0:ROOT_W];
    t_carry                  r_sc    [0:ROOT_W];
    logic [RAD_W-1:0]        r_srem  [0:ROOT_W][0:1];
    logic [ROOT_W-1:0]       r_sroot [0:ROOT_W][0:1];
    logic [DIFF_W-1:0]       r_sdm   [0:ROOT_W][0:1];
    logic [RAD_W-1:0]        n_strial [0:ROOT_W-1][0:1];
    logic [RAD_W-1:0]        n_srem   [1:ROOT_W][0:1];
    logic [ROOT_W-1:0]       n_sroot  [1:ROOT_W][0:1];

    // divider pipeline, entry 0 holds the products
    logic                    r_dv   [0:ROOT_W];
    t_carry                  r_dc   [0:ROOT_W];
    logic                    r_ddeg [0:ROOT_W];
    logic [ROOT_W-1:0]       r_dl2  [0:ROOT_W];
    logic [RAD_W-1:0]        r_drem [0:ROOT_W][0:1];
    logic [ROOT_W-1:0]       r_dq   [0:ROOT_W][0:1];
    logic [RAD_W-1:0]        n_dsub [0:ROOT_W-1];
    logic [RAD_W-1:0]        n_drem [1:ROOT_W][0:1];
    logic [ROOT_W-1:0]       n_dq   [1:ROOT_W][0:1];

    // midpoint and coefficients
    logic                    r_fv;
    logic                    r_fdeg;
    t_coord                  r_fvx;
    t_coord                  r_fvy;
    t_coef                   r_fmx;
    t_coef                   r_fmy;
    t_coef                   r_fa;
    t_coef                   r_fb;
    logic signed [SUM_W-1:0] n_fs  [0:1];
    logic signed [SUM_W-1:0] n_fsum [0:1];
    t_coef                   n_fm  [0:1];

    // products for C
    logic                     r_gv;
    logic                     r_gdeg;
    t_coef                    r_ga;
    t_coef                    r_gb;
    logic signed [PROD_W-1:0] r_gp1;
    logic signed [PROD_W-1:0] r_gp2;

    // output register
    logic                     r_ov;
    logic                     r_odeg;
    t_coef                    r_oa;
    t_coef                    r_ob;
    t_cval                    r_oc;
    logic signed [CALC_W-1:0] n_cdiff;
    t_cval                    n_csat;

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    assign n_d[0] = DIFF_W'(i_in.right_x) - DIFF_W'(i_in.vertex_x);
    assign n_d[1] = DIFF_W'(i_in.right_y) - DIFF_W'(i_in.vertex_y);
    assign n_d[2] = DIFF_W'(i_in.left_x) - DIFF_W'(i_in.vertex_x);
    assign n_d[3] = DIFF_W'(i_in.left_y) - DIFF_W'(i_in.vertex_y);

    always_comb begin
        for (int j = 0; j < ROOT_W; j++) begin
            for (int l = 0; l < 2; l++) begin
                n_strial[j][l] = (RAD_W'(r_sroot[j][l]) << (ROOT_W - j))
                               | (RAD_W'(1) << (2 * (ROOT_W - 1 - j)));
                if (r_srem[j][l] >= n_strial[j][l]) begin
                    n_srem[j+1][l]  = r_srem[j][l] - n_strial[j][l];
                    n_sroot[j+1][l] = r_sroot[j][l] | (ROOT_W'(1) << (ROOT_W - 1 - j));
                end else begin
                    n_srem[j+1][l]  = r_srem[j][l];
                    n_sroot[j+1][l] = r_sroot[j][l];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < ROOT_W; j++) begin
            n_dsub[j] = RAD_W'(r_dl2[j]) << (ROOT_W - 1 - j);
            for (int l = 0; l < 2; l++) begin
                if (r_drem[j][l] >= n_dsub[j]) begin
                    n_drem[j+1][l] = r_drem[j][l] - n_dsub[j];
                    n_dq[j+1][l]   = r_dq[j][l] | (ROOT_W'(1) << (ROOT_W - 1 - j));
                end else begin
                    n_drem[j+1][l] = r_drem[j][l];
                    n_dq[j+1][l]   = r_dq[j][l];
                end
            end
        end
    end

    always_comb begin
        n_fs[0]   = r_dc[ROOT_W].nx ? -SUM_W'(r_dq[ROOT_W][0]) : SUM_W'(r_dq[ROOT_W][0]);
        n_fs[1]   = r_dc[ROOT_W].ny ? -SUM_W'(r_dq[ROOT_W][1]) : SUM_W'(r_dq[ROOT_W][1]);
        n_fsum[0] = SUM_W'(r_dc[ROOT_W].rx) + SUM_W'(r_dc[ROOT_W].vx) + n_fs[0];
        n_fsum[1] = SUM_W'(r_dc[ROOT_W].ry) + SUM_W'(r_dc[ROOT_W].vy) + n_fs[1];
        n_fm[0]   = COEF_W'(n_fsum[0] >>> 1);
        n_fm[1]   = COEF_W'(n_fsum[1] >>> 1);
    end

    always_comb begin
        n_cdiff = CALC_W'(r_gp1) - CALC_W'(r_gp2);
        if (!n_cdiff[CALC_W-1] && (n_cdiff[CALC_W-2:C_W-1] != '0)) begin
            n_csat = {1'b0, {(C_W-1){1'b1}}};
        end else if (n_cdiff[CALC_W-1] && (n_cdiff[CALC_W-2:C_W-1] != '1)) begin
            n_csat = {1'b1, {(C_W-1){1'b0}}};
        end else begin
            n_csat = C_W'(n_cdiff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0v <= 1'b0;
            r_s1v <= 1'b0;
            for (int j = 0; j <= ROOT_W; j++) begin
                r_sv[j] <= 1'b0;
                r_dv[j] <= 1'b0;
            end
            r_fv <= 1'b0;
            r_gv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_s0v   <= i_in.valid;
            r_s1v   <= r_s0v;
            r_sv[0] <= r_s1v;
            r_dv[0] <= r_sv[ROOT_W];
            for (int j = 0; j < ROOT_W; j++) begin
                r_sv[j+1] <= r_sv[j];
                r_dv[j+1] <= r_dv[j];
            end
            r_fv <= r_dv[ROOT_W];
            r_gv <= r_fv;
            r_ov <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0c.vx <= i_in.vertex_x;
            r_s0c.vy <= i_in.vertex_y;
            r_s0c.rx <= i_in.right_x;
            r_s0c.ry <= i_in.right_y;
            r_s0c.nx <= n_d[2][DIFF_W-1];
            r_s0c.ny <= n_d[3][DIFF_W-1];
            for (int k = 0; k < 4; k++) begin
                r_s0m[k] <= f_mag(n_d[k]);
            end

            r_s1c <= r_s0c;
            for (int k = 0; k < 4; k++) begin
                r_s1q[k] <= RAD_W'(r_s0m[k]) * RAD_W'(r_s0m[k]);
            end
            r_s1m[0] <= r_s0m[2];
            r_s1m[1] <= r_s0m[3];

            r_sc[0]         <= r_s1c;
            r_srem[0][0]    <= r_s1q[0] + r_s1q[1];
            r_srem[0][1]    <= r_s1q[2] + r_s1q[3];
            r_sroot[0][0]   <= '0;
            r_sroot[0][1]   <= '0;
            r_sdm[0][0]     <= r_s1m[0];
            r_sdm[0][1]     <= r_s1m[1];
            for (int j = 0; j < ROOT_W; j++) begin
                r_sc[j+1] <= r_sc[j];
                for (int l = 0; l < 2; l++) begin
                    r_srem[j+1][l]  <= n_srem[j+1][l];
                    r_sroot[j+1][l] <= n_sroot[j+1][l];
                    r_sdm[j+1][l]   <= r_sdm[j][l];
                end
            end

            r_dc[0]   <= r_sc[ROOT_W];
            r_dl2[0]  <= r_sroot[ROOT_W][1];
            r_ddeg[0] <= (r_sroot[ROOT_W][1] == '0);
            for (int l = 0; l < 2; l++) begin
                r_drem[0][l] <= RAD_W'(r_sroot[ROOT_W][0]) * RAD_W'(r_sdm[ROOT_W][l]);
                r_dq[0][l]   <= '0;
            end
            for (int j = 0; j < ROOT_W; j++) begin
                r_dc[j+1]   <= r_dc[j];
                r_dl2[j+1]  <= r_dl2[j];
                r_ddeg[j+1] <= r_ddeg[j];
                for (int l = 0; l < 2; l++) begin
                    r_drem[j+1][l] <= n_drem[j+1][l];
                    r_dq[j+1][l]   <= n_dq[j+1][l];
                end
            end

            r_fdeg <= r_ddeg[ROOT_W];
            r_fvx  <= r_dc[ROOT_W].vx;
            r_fvy  <= r_dc[ROOT_W].vy;
            r_fmx  <= n_fm[0];
            r_fmy  <= n_fm[1];
            r_fa   <= COEF_W'(r_dc[ROOT_W].vy) - n_fm[1];
            r_fb   <= n_fm[0] - COEF_W'(r_dc[ROOT_W].vx);

            r_gdeg <= r_fdeg;
            r_ga   <= r_fa;
            r_gb   <= r_fb;
            r_gp1  <= PROD_W'(r_fmy) * PROD_W'(r_fvx);
            r_gp2  <= PROD_W'(r_fmx) * PROD_W'(r_fvy);

            r_odeg <= r_gdeg;
            r_oa   <= r_gdeg ? '0 : r_ga;
            r_ob   <= r_gdeg ? '0 : r_gb;
            r_oc   <= r_gdeg ? '0 : n_csat;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.degenerate = r_odeg;
    assign o_out.coef_a     = r_oa;
    assign o_out.coef_b     = r_ob;
    assign o_out.coef_c     = r_oc;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |->
            o_out.coef_a == '0 && o_out.coef_b == '0 && o_out.coef_c == '0)
        else $error("degenerate result with nonzero coefficients");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[ROOT_W] |->
            r_srem[ROOT_W][0] <= (RAD_W'(r_sroot[ROOT_W][0]) << 1) &&
            r_srem[ROOT_W][1] <= (RAD_W'(r_sroot[ROOT_W][1]) << 1))
        else $error("square root remainder out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[ROOT_W] && !r_ddeg[ROOT_W] |->
            r_drem[ROOT_W][0] < RAD_W'(r_dl2[ROOT_W]) &&
            r_drem[ROOT_W][1] < RAD_W'(r_dl2[ROOT_W]))
        else $error("divider remainder not below divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=>
            r_ov && $stable(r_oc) && $stable(r_oa) && $stable(r_ob))
        else $error("stalled result not held");
endmodule

// ===== tb/sv/angle_bisector_line_coeffs_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for angle_bisector_line_coeffs_unit: directed table then random items,
// each result checked against a typed table line or a built-in bisector line predictor.
// Depends on abl_pkg and the stream interfaces in abl_if.sv.
module angle_bisector_line_coeffs_unit_tb;
    import abl_pkg::*;

    typedef struct packed {
        t_coord vx;
        t_coord vy;
        t_coord rx;
        t_coord ry;
        t_coord lx;
        t_coord ly;
    } t_points;

    typedef struct packed {
        t_coef a;
        t_coef b;
        t_cval c;
        logic  deg;
    } t_line;

    typedef struct packed {
        logic    typed;
        t_points pts;
        t_line   line;
    } t_row;

    localparam t_coord PMAX = 32'sh7FFF_FFFF;
    localparam t_coord PMIN = 32'sh8000_0000;
    localparam t_coord ONE  = 32'sh0001_0000;
    localparam logic signed [127:0] CMAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] CMIN = -CMAX - 1;
    localparam int N_DIR    = 16;
    localparam int N_RAND   = 1950;
    localparam int N_TOTAL  = N_DIR + N_RAND;
    localparam int LATENCY  = 2 * ROOT_W + 7;
    localparam int HOLD_LEN = 400;

    localparam t_row DIRECTED [N_DIR] = '{
        '{1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '{34'sd0, 34'sd0, 64'sd0, 1'b1}},
        '{1'b1, '{PMAX, PMIN, PMIN, PMAX, PMAX, PMIN}, '{34'sd0, 34'sd0, 64'sd0, 1'b1}},
        '{1'b1, '{PMIN, PMIN, PMAX, PMAX, PMIN, PMIN}, '{34'sd0, 34'sd0, 64'sd0, 1'b1}},
        '{1'b1, '{ONE, -ONE, 32'sd5, 32'sd7, ONE, -ONE}, '{34'sd0, 34'sd0, 64'sd0, 1'b1}},
        '{1'b0, '{32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, ONE}, '0},
        '{1'b0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE, ONE}, '0},
        '{1'b0, '{ONE, ONE, ONE, ONE, -ONE, 32'sd3}, '0},
        '{1'b0, '{PMAX, PMIN, PMIN, PMAX, PMIN, PMAX}, '0},
        '{1'b0, '{PMIN, PMAX, PMAX, PMIN, PMAX, PMIN}, '0},
        '{1'b0, '{PMAX, PMAX, PMIN, PMIN, PMIN, PMAX}, '0},
        '{1'b0, '{PMIN, PMIN, PMAX, PMAX, PMAX, PMIN}, '0},
        '{1'b0, '{PMAX, PMIN, PMAX, PMIN, PMIN, PMAX}, '0},
        '{1'b0, '{PMIN, PMAX, PMIN, PMIN, PMAX, PMAX}, '0},
        '{1'b0, '{32'sd0, 32'sd0, PMAX, 32'sd0, 32'sd1, 32'sd0}, '0},
        '{1'b0, '{32'sd0, 32'sd0, 32'sd1, 32'sd0, PMIN, PMIN}, '0},
        '{1'b0, '{-ONE, ONE, -32'sd1, 32'sd1, 32'sd1, -32'sd1}, '0}
    };

    logic i_clk;
    logic i_rst_n;
    abl_in_if  in_ch ();
    abl_out_if out_ch ();

    angle_bisector_line_coeffs_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_line pending_lines[$];
    int    mismatches = 0;
    int    send_idle  = 13;
    int    recv_idle  = 54;
    int    sent       = 0;
    int    received   = 0;
    int    hold_left  = 0;
    bit    held       = 0;

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [127:0] ray_length(logic signed [127:0] dx, logic signed [127:0] dy);
        logic [127:0] s;
        logic [127:0] r;
        logic [127:0] t;
        s = mag128(dx) * mag128(dx) + mag128(dy) * mag128(dy);
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] scale_axis(logic [127:0] l1, logic [127:0] l2,
                                                       logic signed [127:0] d);
        logic [127:0] m;
        m = (l1 * mag128(d)) / l2;
        return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_line bisector_line(t_points p);
        logic signed [127:0] vx, vy, rx, ry, lx, ly, mx, my, c;
        logic [127:0] l1, l2;
        t_line res;
        vx = p.vx; vy = p.vy; rx = p.rx; ry = p.ry; lx = p.lx; ly = p.ly;
        res = '0;
        l1 = ray_length(rx - vx, ry - vy);
        l2 = ray_length(lx - vx, ly - vy);
        if (l2 == 0) begin
            res.deg = 1'b1;
            return res;
        end
        mx = (rx + vx + scale_axis(l1, l2, lx - vx)) >>> 1;
        my = (ry + vy + scale_axis(l1, l2, ly - vy)) >>> 1;
        c = my * vx - mx * vy;
        if (c > CMAX) c = CMAX;
        if (c < CMIN) c = CMIN;
        res.a = t_coef'(vy - my);
        res.b = t_coef'(mx - vx);
        res.c = t_cval'(c);
        return res;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(3))
            0: return t_coord'($urandom_range(2 * 1048576) - 1048576);
            1: return t_coord'($urandom_range(2 * 16777216) - 16777216);
            2: return $urandom_range(1) ? PMAX - t_coord'($urandom_range(255))
                                        : PMIN + t_coord'($urandom_range(255));
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_points rand_points();
        t_points p;
        p.vx = rand_coord(); p.vy = rand_coord();
        p.rx = rand_coord(); p.ry = rand_coord();
        p.lx = rand_coord(); p.ly = rand_coord();
        case ($urandom_range(19))
            0: begin
                p.lx = p.vx; p.ly = p.vy;
            end
            1: begin
                p.rx = p.vx; p.ry = p.vy;
            end
            2: begin
                p.lx = p.vx + t_coord'($urandom_range(2) - 1);
                p.ly = p.vy + t_coord'($urandom_range(2) - 1);
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("angle_bisector_line_coeffs_unit_tb: errors");
        $finish;
    end

    // receiver side: ready, long hold-off and result checking
    always @(posedge i_clk) begin
        t_line want;
        t_line got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.coef_a, out_ch.coef_b, out_ch.coef_c, out_ch.degenerate};
            received <= received + 1;
            if (pending_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_lines.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!held && received >= 800) begin
            held <= 1;
            hold_left <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        t_points cur;
        cur = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.vertex_x, in_ch.vertex_y, in_ch.right_x, in_ch.right_y,
         in_ch.left_x, in_ch.left_y} = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (sent < N_TOTAL) begin
            @(posedge i_clk);
            if (in_ch.valid && in_ch.ready) begin
                if (sent < N_DIR && DIRECTED[sent].typed)
                    pending_lines.push_back(DIRECTED[sent].line);
                else
                    pending_lines.push_back(bisector_line(cur));
                sent++;
                if (sent == N_DIR + 650) begin
                    send_idle = 54; recv_idle = 13;
                end else if (sent == N_DIR + 1300) begin
                    send_idle = 0; recv_idle = 0;
                end
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (sent < N_TOTAL && $urandom_range(99) >= send_idle) begin
                    cur = sent < N_DIR ? DIRECTED[sent].pts : rand_points();
                    in_ch.vertex_x <= cur.vx;
                    in_ch.vertex_y <= cur.vy;
                    in_ch.right_x  <= cur.rx;
                    in_ch.right_y  <= cur.ry;
                    in_ch.left_x   <= cur.lx;
                    in_ch.left_y   <= cur.ly;
                    in_ch.valid    <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("angle_bisector_line_coeffs_unit_tb: clean");
        else
            $display("angle_bisector_line_coeffs_unit_tb: errors");
        $finish;
    end
endmodule
